FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/wbrml_pkg.sv
// ----------------------------------------------------------------------------
// wbrml_pkg
// Types and constants shared by the byte rate meter controller and datapath.
// ----------------------------------------------------------------------------
package wbrml_pkg;

   localparam int TIME_W   = 32;
   localparam int BYTES_W  = 16;
   localparam int RATE_W   = 32;
   localparam int DELAY_W  = 10;
   localparam int TOTAL_W  = 48;

   // total * 1000 fits in 58 bits; 1000 = 1024 - 16 - 8
   localparam int MUL_SH_HI  = 10;
   localparam int MUL_SH_MID = 4;
   localparam int MUL_SH_LO  = 3;
   localparam int PROD_W     = TOTAL_W + MUL_SH_HI;
   localparam int DIV_STEPS  = PROD_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [TOTAL_W-1:0] MAX48     = {TOTAL_W{1'b1}};
   localparam logic [RATE_W-1:0]  MAX32     = {RATE_W{1'b1}};
   localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_CHUNK  = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic [TIME_W-1:0]  time_ms;
      logic [BYTES_W-1:0] byte_count;
   } req_type;

   typedef struct packed {
      logic [RATE_W-1:0]  current_rate;
      logic [DELAY_W-1:0] delay_ms;
      logic [BYTES_W-1:0] next_request;
      logic [TOTAL_W-1:0] total_rate;
      logic [TOTAL_W-1:0] total_bytes;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_DIV,
      ST_WRITE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic div_step;
      logic commit;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_div;
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

FILE: rtl/core/wbrml_ctrl.sv
// ----------------------------------------------------------------------------
// wbrml_ctrl
// Sequencer: accepts an item, steps the multiply and divide for a finish
// with bytes and elapsed time, then commits the result once the output register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wbrml_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  wbrml_pkg::dp_status_type status,
   output wbrml_pkg::dp_cmd_type   cmd
);
   import wbrml_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.need_div ? ST_MUL1 : ST_WRITE;
            end
         end
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_MUL1:  cmd.mul1     = 1'b1;
         ST_MUL2:  cmd.mul2     = 1'b1;
         ST_DIV:   cmd.div_step = 1'b1;
         ST_WRITE: cmd.commit   = status.out_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   `ASSERT_ALWAYS(a_cmd_onehot, clock, reset, $onehot0(cmd), "more than one datapath command")
   `ASSERT_ALWAYS(a_commit_free, clock, reset, !cmd.commit || status.out_free, "commit into a full output register")
   `ASSERT_NEXT(a_finish_mul, clock, reset, cmd.load && status.need_div, state_ff == ST_MUL1, "finish did not start the multiply")

endmodule

FILE: rtl/core/wbrml_dp.sv
// ----------------------------------------------------------------------------
// wbrml_dp
// Meter state, shift-subtract multiply by 1000, restoring divider and the
// output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wbrml_dp #(
   parameter int BLOCK_MAX = 8192,
   parameter int WINDOW_MS = 1000
) (
   input  logic                      clock,
   input  logic                      reset,
   input  wbrml_pkg::req_type        req_data,
   input  logic                      csr_valid,
   input  logic [31:0]               csr_wdata,
   input  wbrml_pkg::dp_cmd_type     cmd,
   output wbrml_pkg::dp_status_type  status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output wbrml_pkg::rsp_type        rsp_data
);
   import wbrml_pkg::*;

   localparam logic [TIME_W-1:0]  WIN     = TIME_W'(WINDOW_MS);
   localparam logic [BYTES_W-1:0] BLK     = BYTES_W'(BLOCK_MAX);

   logic [RATE_W-1:0]    limit_ff;
   logic [TIME_W-1:0]    start_ff, start_in;
   logic [TIME_W-1:0]    wstart_ff, wstart_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [RATE_W-1:0]    wbytes_ff, wbytes_in;
   logic [RATE_W-1:0]    rate_ff, rate_in;

   req_type              item_ff;
   logic [TIME_W-1:0]    el_ff;
   logic                 need_div_ff;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [RATE_W:0]      rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [TIME_W-1:0]    req_el;
   logic [PROD_W-1:0]    x_ext;
   logic [RATE_W:0]      rem_sh;
   logic                 q_bit;
   logic [TOTAL_W-1:0]   quot_sat;
   logic [BYTES_W-1:0]   next_req;

   logic [TIME_W-1:0]    in_win, since_start, delay_full;
   logic [TOTAL_W:0]     total_sum;
   logic [RATE_W:0]      wb_sum;
   logic [RATE_W-1:0]    wb_new;
   logic [DELAY_W-1:0]   delay;
   logic [TOTAL_W-1:0]   trate;

   // status toward the controller
   assign req_el          = req_data.time_ms - start_ff;
   assign status.need_div = (req_data.command == CMD_FINISH) && (total_ff != '0)
                            && (req_el != '0);
   assign status.div_last = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign next_req = (limit_ff != '0 && limit_ff < RATE_W'(BLK))
                     ? limit_ff[BYTES_W-1:0] : BLK;

   // multiply and divide
   assign x_ext    = PROD_W'(total_ff);
   assign rem_sh   = {rem_ff[RATE_W-1:0], prod_ff[PROD_W-1]};
   assign q_bit    = (rem_sh >= {1'b0, el_ff});
   assign quot_sat = (|prod_ff[PROD_W-1:TOTAL_W]) ? MAX48 : prod_ff[TOTAL_W-1:0];

   always_comb begin
      prod_in = prod_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (cmd.mul1) begin
         prod_in = (x_ext << MUL_SH_HI) - (x_ext << MUL_SH_MID);
         rem_in  = '0;
         cnt_in  = '0;
      end else if (cmd.mul2) begin
         prod_in = prod_ff - (x_ext << MUL_SH_LO);
      end else if (cmd.div_step) begin
         prod_in = {prod_ff[PROD_W-2:0], q_bit};
         rem_in  = q_bit ? (rem_sh - {1'b0, el_ff}) : rem_sh;
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
      end
   end

   // meter update and result fields, used on commit
   assign in_win      = item_ff.time_ms - wstart_ff;
   assign since_start = item_ff.time_ms - start_ff;
   assign total_sum   = {1'b0, total_ff} + (TOTAL_W + 1)'(item_ff.byte_count);
   assign wb_sum      = {1'b0, wbytes_ff} + (RATE_W + 1)'(item_ff.byte_count);
   assign wb_new      = wb_sum[RATE_W] ? MAX32 : wb_sum[RATE_W-1:0];
   assign delay_full  = WIN - in_win;

   always_comb begin
      start_in  = start_ff;
      wstart_in = wstart_ff;
      total_in  = total_ff;
      wbytes_in = wbytes_ff;
      rate_in   = rate_ff;
      delay     = '0;
      trate     = '0;
      case (item_ff.command)
         CMD_START: begin
            start_in  = item_ff.time_ms;
            wstart_in = item_ff.time_ms;
            total_in  = '0;
            wbytes_in = '0;
            rate_in   = '0;
         end
         CMD_CHUNK: begin
            if (item_ff.byte_count != '0) begin
               total_in = total_sum[TOTAL_W] ? MAX48 : total_sum[TOTAL_W-1:0];
               if (in_win < WIN) begin
                  wbytes_in = wb_new;
                  if (since_start < WIN) begin
                     rate_in = wb_new;
                  end
                  if (limit_ff != '0 && wb_new >= limit_ff) begin
                     delay = (delay_full > TIME_W'(DELAY_MAX))
                             ? DELAY_MAX : delay_full[DELAY_W-1:0];
                  end
               end else begin
                  rate_in   = wbytes_ff;
                  wstart_in = item_ff.time_ms;
                  wbytes_in = '0;
               end
            end
         end
         CMD_FINISH: begin
            trate = need_div_ff ? quot_sat : total_ff;
         end
         default: begin
            trate = '0;
         end
      endcase
   end

   always_comb begin
      rsp_in              = rsp_ff;
      rsp_in.current_rate = rate_in;
      rsp_in.delay_ms     = delay;
      rsp_in.next_request = next_req;
      rsp_in.total_rate   = trate;
      rsp_in.total_bytes  = total_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and meter state
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= '0;
         start_ff     <= '0;
         wstart_ff    <= '0;
         total_ff     <= '0;
         wbytes_ff    <= '0;
         rate_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_wdata;
         end
         if (cmd.commit) begin
            start_ff  <= start_in;
            wstart_ff <= wstart_in;
            total_ff  <= total_in;
            wbytes_ff <= wbytes_in;
            rate_ff   <= rate_in;
         end
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff     <= req_data;
         el_ff       <= req_el;
         need_div_ff <= status.need_div;
      end
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_NEXT(a_commit_valid, clock, reset, cmd.commit, rsp_valid_ff, "commit did not raise result valid")
   `ASSERT_ALWAYS(a_rem_bound, clock, reset, !cmd.div_step || rem_ff < {1'b0, el_ff}, "divider remainder not below divisor")

endmodule

FILE: rtl/core/windowed_byte_rate_meter_limiter_top.sv
// ----------------------------------------------------------------------------
// windowed_byte_rate_meter_limiter_top
// Meters a byte stream in fixed millisecond windows, asks for throttling
// delays against a byte limit and reports the average rate on finish.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_ready  req_data  (command, time, bytes)
//  rsp_      out        rsp_valid / rsp_ready  rsp_data  (rates, delay, sizes)
//  csr_      in         csr_valid / csr_ready  csr_wdata (byte limit, 0 = none)
//
//  Start, chunk and unused commands, and a finish with no bytes or no
//  elapsed time, go from accept to commit. Other finishes run the multiply
//  (MUL1, MUL2), then the one-bit-per-cycle restoring divider (58 steps).
//  Reset is synchronous and clears limit, meter state and result valid.
//  A result waiting in the output register does not block the next
//  transfer in; the commit of that item waits until the register is free.
//  csr_ready is always high; the user must write the limit only while idle.
// ----------------------------------------------------------------------------
module windowed_byte_rate_meter_limiter_top #(
   parameter int BLOCK_MAX = 8192,
   parameter int WINDOW_MS = 1000
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  wbrml_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output wbrml_pkg::rsp_type  rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [31:0]         csr_wdata
);
   import wbrml_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // limit register takes every write at once
   assign csr_ready = 1'b1;

   // sequencer: one item in flight
   wbrml_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // meter state, multiply/divide unit and output register
   wbrml_dp #(
      .BLOCK_MAX (BLOCK_MAX),
      .WINDOW_MS (WINDOW_MS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/windowed_byte_rate_meter_limiter_top_tb.sv
// ----------------------------------------------------------------------------
// windowed_byte_rate_meter_limiter_top_tb
// Self-checking bench for the windowed byte rate meter and limiter. A
// directed table covers reset state, extremes and corner timing, then
// random transfers run under a series of byte limits. Every result is
// checked field by field against an in-bench meter model or a hand-typed one.
// ----------------------------------------------------------------------------
module windowed_byte_rate_meter_limiter_top_tb;
   import wbrml_pkg::*;

   localparam int          BLOCK_MAX_P    = 8192;
   localparam int          WINDOW_MS_P    = 1000;
   localparam logic [31:0] WINDOW_LEN     = 32'd1000;
   localparam logic [15:0] BLOCK_LEN      = 16'd8192;
   localparam logic [1:0]  CMD_UNUSED     = 2'd3;
   localparam int          SETTLE_CYCLES  = 4;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          STEADY_AFTER   = 450;   // no idling past this count
   localparam int          PHASES         = 11;
   localparam int          PHASE_ITEMS    = 40;

   typedef enum bit {ROW_ITEM, ROW_LIMIT} row_kind_type;

   // one line of the directed table
   typedef struct {
      row_kind_type kind;
      req_type      item;
      logic [31:0]  limit;
      bit           fixed;  // want holds a hand-typed result
      rsp_type      want;
   } stim_row_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_wdata = '0;

   // meter model state
   logic [31:0] limit_reg    = '0;
   logic [31:0] xfer_start   = '0;
   logic [31:0] win_start    = '0;
   logic [47:0] bytes_total  = '0;
   logic [31:0] win_bytes    = '0;
   logic [31:0] rate_est     = '0;

   rsp_type      expected_q[$];
   stim_row_type directed_rows[$];

   bit          steady        = 1'b0;
   int          failures      = 0;
   int          items_sent    = 0;
   int          finishes_sent = 0;
   int          results_seen  = 0;
   int          delays_seen   = 0;
   int          limit_writes  = 0;

   windowed_byte_rate_meter_limiter_top #(
      .BLOCK_MAX(BLOCK_MAX_P),
      .WINDOW_MS(WINDOW_MS_P)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Meter model: advances the state by one event and returns its result.
   // ------------------------------------------------------------------------
   function automatic rsp_type meter_step(input req_type item);
      rsp_type     res;
      logic [31:0] in_win;
      logic [31:0] since_start;
      logic [31:0] elapsed;
      logic [31:0] wait_ms;
      logic [48:0] sum48;
      logic [32:0] sum32;
      logic [63:0] prod;
      logic [63:0] quot;
      logic [9:0]  delay;
      logic [47:0] trate;
      delay = '0;
      trate = '0;
      case (item.command)
         CMD_START: begin
            xfer_start  = item.time_ms;
            win_start   = item.time_ms;
            bytes_total = '0;
            win_bytes   = '0;
            rate_est    = '0;
         end
         CMD_CHUNK: begin
            // an empty chunk leaves the state alone
            if (item.byte_count != '0) begin
               in_win      = item.time_ms - win_start;
               since_start = item.time_ms - xfer_start;
               sum48       = {1'b0, bytes_total} + item.byte_count;
               bytes_total = sum48[48] ? MAX48 : sum48[47:0];
               if (in_win < WINDOW_LEN) begin
                  sum32     = {1'b0, win_bytes} + item.byte_count;
                  win_bytes = sum32[32] ? MAX32 : sum32[31:0];
                  if (since_start < WINDOW_LEN) rate_est = win_bytes;
                  if (limit_reg != '0 && win_bytes >= limit_reg) begin
                     wait_ms = WINDOW_LEN - in_win;
                     delay   = (wait_ms > {22'd0, DELAY_MAX}) ? DELAY_MAX : wait_ms[9:0];
                  end
               end else begin
                  // window over: report, restart here, chunk not in window
                  rate_est  = win_bytes;
                  win_start = item.time_ms;
                  win_bytes = '0;
               end
            end
         end
         CMD_FINISH: begin
            elapsed = item.time_ms - xfer_start;
            if (bytes_total != '0 && elapsed != '0) begin
               prod  = {16'd0, bytes_total} * 64'd1000;
               quot  = prod / {32'd0, elapsed};
               trate = (quot > {16'd0, MAX48}) ? MAX48 : quot[47:0];
            end else begin
               trate = bytes_total;
            end
         end
         default: ;
      endcase
      res.current_rate = rate_est;
      res.delay_ms     = delay;
      res.next_request = (limit_reg != '0 && limit_reg < {16'd0, BLOCK_LEN}) ?
                         limit_reg[15:0] : BLOCK_LEN;
      res.total_rate   = trate;
      res.total_bytes  = bytes_total;
      return res;
   endfunction

   function automatic req_type mk_req(input logic [1:0] cmd, input logic [31:0] t,
                                      input logic [15:0] b);
      req_type r;
      r.command    = cmd;
      r.time_ms    = t;
      r.byte_count = b;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(input logic [31:0] rate, input logic [9:0] dly,
                                      input logic [15:0] nxt, input logic [47:0] tr,
                                      input logic [47:0] tb);
      rsp_type r;
      r.current_rate = rate;
      r.delay_ms     = dly;
      r.next_request = nxt;
      r.total_rate   = tr;
      r.total_bytes  = tb;
      return r;
   endfunction

   function automatic logic [15:0] pick_bytes();
      int sel;
      sel = $urandom_range(0, 7);
      case (sel)
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(1, 16));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Directed table builders
   // ------------------------------------------------------------------------
   task automatic add_item(input logic [1:0] cmd, input logic [31:0] t,
                           input logic [15:0] b);
      stim_row_type row;
      row.kind  = ROW_ITEM;
      row.item  = mk_req(cmd, t, b);
      row.limit = '0;
      row.fixed = 1'b0;
      row.want  = '0;
      directed_rows.push_back(row);
   endtask

   task automatic add_fixed(input logic [1:0] cmd, input logic [31:0] t,
                            input logic [15:0] b, input rsp_type want);
      stim_row_type row;
      row.kind  = ROW_ITEM;
      row.item  = mk_req(cmd, t, b);
      row.limit = '0;
      row.fixed = 1'b1;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   task automatic add_limit(input logic [31:0] value);
      stim_row_type row;
      row.kind  = ROW_LIMIT;
      row.item  = '0;
      row.limit = value;
      row.fixed = 1'b0;
      row.want  = '0;
      directed_rows.push_back(row);
   endtask

   // ------------------------------------------------------------------------
   // Request transfer: optional idle burst, then hold valid until accepted.
   // Called at a rising-edge step; returns at the step of acceptance with
   // valid still high, so the caller either drives the next item or drops it.
   // ------------------------------------------------------------------------
   task automatic send_item(input req_type item, input bit fixed, input rsp_type want);
      rsp_type predicted;
      int      gap;
      gap = 0;
      if (!steady && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!(req_valid && req_ready));
      predicted = meter_step(item);
      expected_q.push_back(fixed ? want : predicted);
      items_sent++;
      if (item.command == CMD_FINISH) finishes_sent++;
   endtask

   // Limit write: only with the block idle and every result back.
   task automatic write_limit(input logic [31:0] value);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      limit_reg = value;
      limit_writes++;
   endtask

   task automatic check_field(input string name, input logic [47:0] want,
                              input logic [47:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side: random stall bursts, none once the run goes steady
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_stall
      int stall_left;
      if (steady) begin
         rsp_ready  <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
      end
   end

   // every result transfer is matched against the oldest expectation
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_data.delay_ms != '0) delays_seen++;
         if (expected_q.size() == 0) begin
            $error("result transfer with nothing pending");
            failures++;
         end else begin
            want = expected_q.pop_front();
            check_field("current_rate", {16'd0, want.current_rate},
                        {16'd0, rsp_data.current_rate});
            check_field("delay_ms", {38'd0, want.delay_ms}, {38'd0, rsp_data.delay_ms});
            check_field("next_request", {32'd0, want.next_request},
                        {32'd0, rsp_data.next_request});
            check_field("total_rate", want.total_rate, rsp_data.total_rate);
            check_field("total_bytes", want.total_bytes, rsp_data.total_bytes);
         end
      end
   end

   // watchdog: too many cycles without any transfer ends the run
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[windowed_byte_rate_meter_limiter_top] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : main_seq
      int          phase;
      int          n;
      int          k;
      int          sel;
      int          phase_end;
      logic [31:0] t;
      logic [31:0] t0;
      logic [31:0] lim;
      logic [31:0] rnd;
      logic [1:0]  cmd;

      // limit is zero after reset: next_request is the block maximum
      add_fixed(CMD_FINISH, 32'd0, 16'd0, mk_rsp(32'd0, 10'd0, 16'd8192, 48'd0, 48'd0));
      add_fixed(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF,
                mk_rsp(32'd0, 10'd0, 16'd8192, 48'd0, 48'd0));
      // chunk with no start: counts against the zero reset window
      add_fixed(CMD_CHUNK, 32'd0, 16'hFFFF,
                mk_rsp(32'd65535, 10'd0, 16'd8192, 48'd0, 48'd65535));
      add_fixed(CMD_START, 32'hFFFF_FC00, 16'hFFFF,
                mk_rsp(32'd0, 10'd0, 16'd8192, 48'd0, 48'd0));
      add_item(CMD_CHUNK, 32'hFFFF_FD00, 16'd1);
      add_item(CMD_CHUNK, 32'hFFFF_FFE0, 16'd100);
      add_item(CMD_CHUNK, 32'h0000_0010, 16'd7);     // time crosses the wrap, window ends
      add_item(CMD_CHUNK, 32'h0000_0020, 16'd0);     // empty chunk
      add_item(CMD_CHUNK, 32'h0000_0000, 16'd5);     // older than window start
      add_item(CMD_FINISH, 32'h0000_0100, 16'hFFFF);
      // finish with no elapsed time reports the byte total
      add_fixed(CMD_START, 32'd1000, 16'd0, mk_rsp(32'd0, 10'd0, 16'd8192, 48'd0, 48'd0));
      add_fixed(CMD_CHUNK, 32'd1000, 16'd500,
                mk_rsp(32'd500, 10'd0, 16'd8192, 48'd0, 48'd500));
      add_fixed(CMD_FINISH, 32'd1000, 16'd0,
                mk_rsp(32'd500, 10'd0, 16'd8192, 48'd500, 48'd500));
      // smallest limit: first byte hits it, full-window delay
      add_limit(32'd1);
      add_fixed(CMD_START, 32'd0, 16'd0, mk_rsp(32'd0, 10'd0, 16'd1, 48'd0, 48'd0));
      add_fixed(CMD_CHUNK, 32'd0, 16'd1, mk_rsp(32'd1, 10'd1000, 16'd1, 48'd0, 48'd1));
      add_item(CMD_CHUNK, 32'd999, 16'hFFFF);
      add_item(CMD_CHUNK, 32'd1000, 16'd3);
      add_item(CMD_FINISH, 32'd1500, 16'd0);
      // largest limit, one millisecond elapsed
      add_limit(32'hFFFF_FFFF);
      add_fixed(CMD_START, 32'd50, 16'd0, mk_rsp(32'd0, 10'd0, 16'd8192, 48'd0, 48'd0));
      add_item(CMD_CHUNK, 32'd55, 16'hFFFF);
      add_item(CMD_FINISH, 32'd51, 16'd0);
      // limit just under and just over the block maximum
      add_limit(32'd8191);
      add_item(CMD_START, 32'h8000_0000, 16'd0);
      add_item(CMD_CHUNK, 32'h8000_000A, 16'd8191);
      add_item(CMD_CHUNK, 32'h8000_03E7, 16'd1);
      add_limit(32'd8193);
      add_item(CMD_UNUSED, 32'h1234_5678, 16'h5555);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_LIMIT)
            write_limit(directed_rows[i].limit);
         else
            send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
      end

      // random phases, one limit setting each
      t = '0;
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       lim = 32'd0;
            1:       lim = 32'd1;
            2:       lim = 32'd8191;
            3:       lim = 32'd8192;
            4:       lim = 32'd8193;
            5:       lim = 32'd65535;
            6:       lim = 32'hFFFF_FFFF;
            7:       lim = $urandom_range(1, 70000);
            8:       lim = $urandom_range(1000, 200000);
            9:       lim = $urandom;
            default: lim = 32'd0;
         endcase
         write_limit(lim);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            steady = (items_sent >= STEADY_AFTER);
            sel    = $urandom_range(0, 9);
            if (sel < 7) begin
               // well-formed transfer: start, chunks, finish
               t  = $urandom;
               t0 = t;
               send_item(mk_req(CMD_START, t, pick_bytes()), 1'b0, '0);
               n = $urandom_range(0, 12);
               for (k = 0; k < n; k++) begin
                  case ($urandom_range(0, 15))
                     0:       t = t - $urandom_range(1, 50);
                     1, 2:    t = t + $urandom_range(900, 3000);
                     default: t = t + $urandom_range(0, 300);
                  endcase
                  send_item(mk_req(CMD_CHUNK, t, pick_bytes()), 1'b0, '0);
               end
               if ($urandom_range(0, 7) == 0)
                  t = t0;
               else if ($urandom_range(0, 3) != 0)
                  t = t + $urandom_range(1, 2000);
               send_item(mk_req(CMD_FINISH, t, pick_bytes()), 1'b0, '0);
            end else if (sel < 9) begin
               // broken sequence: chunks and finishes with no fresh start
               n = $urandom_range(1, 3);
               for (k = 0; k < n; k++) begin
                  cmd = ($urandom_range(0, 1) != 0) ? CMD_CHUNK : CMD_FINISH;
                  t   = t + $urandom_range(0, 1500);
                  send_item(mk_req(cmd, t, pick_bytes()), 1'b0, '0);
               end
            end else begin
               // noise: any command, any time
               rnd = $urandom;
               cmd = rnd[1:0];
               send_item(mk_req(cmd, $urandom, 16'($urandom_range(0, 65535))), 1'b0, '0);
            end
         end
      end

      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d requests (%0d finishes) over %0d limit settings",
               items_sent, finishes_sent, limit_writes);
      $display("%0d results checked, %0d carried a throttle delay",
               results_seen, delays_seen);
      if (failures == 0)
         $display("[windowed_byte_rate_meter_limiter_top] OK");
      else
         $display("[windowed_byte_rate_meter_limiter_top] ERROR");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/wbrml_pkg.sv
rtl/core/wbrml_ctrl.sv
rtl/core/wbrml_dp.sv
rtl/core/windowed_byte_rate_meter_limiter_top.sv
tb/windowed_byte_rate_meter_limiter_top_tb.sv
